// ===== hw/rtl/cascaded_iir_lowpass_highpass_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded IIR filter
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CASCADED_IIR_LOWPASS_HIGHPASS_ASSERT_SVH
`define CASCADED_IIR_LOWPASS_HIGHPASS_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CIIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CIIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ciir_pkg.sv =====
// ----------------------------------------------------------------------------
// ciir_pkg
// Widths, fixed-point coefficients and helpers of the cascaded IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ciir_pkg;

  localparam int CoefW         = 32;
  localparam int CoefSlots     = 10;
  localparam int CoefIdxW      = 4;
  localparam int SampleW       = 16;
  localparam int OutW          = 24;
  localparam int InFrac        = 8;
  localparam int DefOrder      = 4;
  localparam int DefStateWidth = 48;

  // Rounding shifts: input products keep 30 fraction bits from 35,
  // feedback products keep 30 from 57, outputs keep 8 from 30.
  localparam int ShiftB   = 5;
  localparam int ShiftA   = 27;
  localparam int OutShift = 22;

  localparam logic FiltLp = 1'b0;
  localparam logic FiltHp = 1'b1;

  typedef logic signed [CoefW-1:0] coef_t;

  // Coefficients, real value times 2^27, unused slots zero
  localparam coef_t LpB [CoefSlots] = '{
    32'sd433123, 32'sd1732494, 32'sd2598741, 32'sd1732494, 32'sd433123,
    32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam coef_t LpA [CoefSlots] = '{
    32'sd134217728, -32'sd341999886, 32'sd350298370, -32'sd166047058,
    32'sd30460821, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam coef_t HpB [CoefSlots] = '{
    32'sd130355587, -32'sd521422350, 32'sd782133524, -32'sd521422350,
    32'sd130355587, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam coef_t HpA [CoefSlots] = '{
    32'sd134217728, -32'sd529033588, 32'sd782022407, -32'sd513811095,
    32'sd126604581, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

  // Feed-forward coefficient of one tap
  function automatic coef_t coef_b(logic filt, logic [CoefIdxW-1:0] k);
    coef_t r;
    r = '0;
    if (k < CoefIdxW'(CoefSlots)) begin
      r = filt ? HpB[k] : LpB[k];
    end
    return r;
  endfunction

  // Feedback coefficient of one tap
  function automatic coef_t coef_a(logic filt, logic [CoefIdxW-1:0] k);
    coef_t r;
    r = '0;
    if (k < CoefIdxW'(CoefSlots)) begin
      r = filt ? HpA[k] : LpA[k];
    end
    return r;
  endfunction

  // Saturate a 65-bit sum to 64 signed bits
  function automatic logic signed [63:0] sat64(logic signed [64:0] v);
    logic signed [63:0] r;
    r = v[63:0];
    if (v[64] != v[63]) begin
      r = v[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cascaded_iir_lowpass_highpass.sv =====
// ----------------------------------------------------------------------------
// cascaded_iir_lowpass_highpass: fixed-point IIR low-pass and high-pass cascade
// Throughput: one sample at a time; the next is taken only after the tap schedule
//   ends, one tap a cycle through the shared multipliers and the four-stage tap pipeline.
// Reset: filter state reads as zero through per-entry valid bits, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_iir_lowpass_highpass_assert.svh"

module cascaded_iir_lowpass_highpass #(
  parameter int ORDER       = ciir_pkg::DefOrder,
  parameter int STATE_WIDTH = ciir_pkg::DefStateWidth
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // tdata: sample_in [15:0]
  input  wire  [ciir_pkg::SampleW-1:0]     s_axis_tdata_i,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: lowpass_out [23:0], highpass_out [47:24]
  output logic [2*ciir_pkg::OutW-1:0]      m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i
);

  import ciir_pkg::*;

  localparam int W        = STATE_WIDTH;
  localparam int KW       = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int AW       = KW + 1;
  localparam int MemDepth = 2 ** AW;
  localparam int LpKStart = 4;
  localparam int HpY      = 4 + ORDER;
  localparam int HpKStart = 8 + ORDER;
  localparam int LastCnt  = 10 + 2 * ORDER;
  localparam int CW       = $clog2(LastCnt + 1);
  localparam int PbW      = CoefW + OutW;
  localparam int MbW      = PbW + 1 - ShiftB;
  localparam int LoW      = 65 - ShiftA;

  localparam logic signed [63:0] HiBound = 64'sd1 <<< (30 + ShiftA);
  localparam logic signed [64:0] WMax    = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMin    = -WMax - 65'sd1;
  localparam logic signed [W:0]  OutRnd  = (W + 1)'(64'sd1 <<< (OutShift - 1));
  localparam logic signed [W:0]  OutMax  = (W + 1)'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam logic signed [W:0]  OutMin  = -OutMax - (W + 1)'(1);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRun  = 1'b1;

  // Control state
  logic [0:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          m_valid_q, m_valid_d;
  logic          out_free, load_out, in_xfer;

  // Sample and filter values
  logic signed [SampleW-1:0] u_q;
  logic signed [W-1:0]       y_q;
  logic signed [OutW-1:0]    lp_q, hp_q, out_lp_q, out_hp_q;

  // Tap issue
  logic                  iss_vld, iss_filt, iss_y, iss_nod;
  logic [CoefIdxW-1:0]   iss_k, iss_km1;
  logic [AW-1:0]         rd_addr, iss_wa;
  logic                  rd_en;
  coef_t                 cb, ca;
  logic signed [OutW-1:0] u_op;
  logic signed [63:0]    y64;
  logic signed [31:0]    yh;
  logic signed [32:0]    yl;
  logic signed [PbW-1:0] prod_b;
  logic signed [63:0]    prod_ah;
  logic signed [64:0]    prod_al;

  // State memory
  logic signed [W-1:0] mem_q [MemDepth];
  logic                mem_vld_q [MemDepth];
  logic signed [W-1:0] rd_q;
  logic                rdv_q;
  logic                wr_en;

  // Product stage
  logic                  p_vld_q, p_y_q, p_nod_q;
  logic [AW-1:0]         p_wa_q;
  logic signed [PbW-1:0] p_b_q;
  logic signed [63:0]    p_ah_q, p_al_q;

  // Rounding stage
  logic                  r_vld_q, r_y_q;
  logic [AW-1:0]         r_wa_q;
  logic signed [MbW-1:0] r_mb_q;
  logic signed [58:0]    r_hic_q;
  logic signed [LoW-1:0] r_lo_q;
  logic signed [W-1:0]   r_dd_q;
  logic signed [PbW:0]   b_rnd;
  logic signed [64:0]    lo_rnd;
  logic signed [63:0]    hic;

  // Sum stage
  logic                s_vld_q, s_y_q;
  logic [AW-1:0]       s_wa_q;
  logic signed [63:0]  s_s1_q, s_ma_q;
  logic signed [63:0]  ma_full;

  // Result stage
  logic signed [64:0]  diff, diff_c;
  logic signed [W-1:0] t_val;

  // Output conversion
  logic signed [W:0]      yo_sum, yo_shr, yo_c;
  logic signed [OutW-1:0] y_out;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign load_out        = (state_q == StRun) && (cnt_q == CW'(LastCnt)) && out_free;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_hp_q, out_lp_q};

  // Sequencer: step through the fixed tap schedule of one sample
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StRun;
          cnt_d   = '0;
        end
      end
      StRun: begin
        if (cnt_q == CW'(LastCnt)) begin
          if (out_free) begin
            state_d = StIdle;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  // Decode which tap of which filter enters the pipeline
  always_comb begin
    iss_vld  = 1'b0;
    iss_filt = FiltLp;
    iss_k    = '0;
    if (state_q == StRun) begin
      if (cnt_q == '0) begin
        iss_vld = 1'b1;
      end else if (cnt_q >= CW'(LpKStart) && cnt_q < CW'(LpKStart + ORDER)) begin
        iss_vld = 1'b1;
        iss_k   = CoefIdxW'(cnt_q - CW'(LpKStart - 1));
      end else if (cnt_q == CW'(HpY)) begin
        iss_vld  = 1'b1;
        iss_filt = FiltHp;
      end else if (cnt_q >= CW'(HpKStart) && cnt_q < CW'(HpKStart + ORDER)) begin
        iss_vld  = 1'b1;
        iss_filt = FiltHp;
        iss_k    = CoefIdxW'(cnt_q - CW'(HpKStart - 1));
      end
    end
    iss_y   = (iss_k == '0);
    iss_nod = (iss_k == CoefIdxW'(ORDER));
    iss_km1 = iss_k - CoefIdxW'(1);
    rd_addr = {iss_filt, iss_k[KW-1:0]};
    iss_wa  = {iss_filt, iss_km1[KW-1:0]};
    rd_en   = iss_vld && !iss_nod;
  end

  // Operands and the shared multipliers; the output tap has no feedback term
  always_comb begin
    cb      = coef_b(iss_filt, iss_k);
    ca      = iss_y ? coef_t'(0) : coef_a(iss_filt, iss_k);
    u_op    = (iss_filt == FiltHp) ? lp_q : {u_q, {InFrac{1'b0}}};
    y64     = iss_y ? 64'sd0 : 64'(y_q);
    yh      = y64[63:32];
    yl      = {1'b0, y64[31:0]};
    prod_b  = cb * u_op;
    prod_ah = ca * yh;
    prod_al = ca * yl;
  end

  // Round the products, clamp the high feedback part
  always_comb begin
    b_rnd  = (PbW + 1)'(p_b_q) + ((PbW + 1)'(1) <<< (ShiftB - 1));
    lo_rnd = 65'(p_al_q) + (65'sd1 <<< (ShiftA - 1));
    hic    = p_ah_q;
    if (p_ah_q > HiBound) begin
      hic = HiBound;
    end else if (p_ah_q < -HiBound) begin
      hic = -HiBound;
    end
  end

  // Combine the feedback product; sum and clamp the tap
  always_comb begin
    ma_full = (64'(r_hic_q) <<< (32 - ShiftA)) + 64'(r_lo_q);
    diff    = 65'(s_s1_q) - 65'(s_ma_q);
    diff_c  = diff;
    if (diff > WMax) begin
      diff_c = WMax;
    end else if (diff < WMin) begin
      diff_c = WMin;
    end
    t_val = diff_c[W-1:0];
    wr_en = s_vld_q && !s_y_q;
  end

  // Scale the filter output to the 8 fraction bit field
  always_comb begin
    yo_sum = (W + 1)'(y_q) + OutRnd;
    yo_shr = yo_sum >>> OutShift;
    yo_c   = yo_shr;
    if (yo_shr > OutMax) begin
      yo_c = OutMax;
    end else if (yo_shr < OutMin) begin
      yo_c = OutMin;
    end
    y_out = yo_c[OutW-1:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      p_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      s_vld_q   <= 1'b0;
      for (int i = 0; i < MemDepth; i++) begin
        mem_vld_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      p_vld_q   <= iss_vld;
      r_vld_q   <= p_vld_q;
      s_vld_q   <= r_vld_q;
      if (wr_en) begin
        mem_vld_q[s_wa_q] <= 1'b1;
      end
    end
  end

  // State memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s_wa_q] <= t_val;
    end
    if (rd_en) begin
      rd_q  <= mem_q[rd_addr];
      rdv_q <= mem_vld_q[rd_addr];
    end
  end

  // Tap pipeline and sample registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      u_q <= s_axis_tdata_i;
    end
    // Product stage
    p_y_q   <= iss_y;
    p_nod_q <= iss_nod;
    p_wa_q  <= iss_wa;
    p_b_q   <= prod_b;
    p_ah_q  <= prod_ah;
    p_al_q  <= prod_al[63:0];
    // Rounding stage
    r_y_q   <= p_y_q;
    r_wa_q  <= p_wa_q;
    r_mb_q  <= b_rnd[PbW:ShiftB];
    r_hic_q <= hic[58:0];
    r_lo_q  <= lo_rnd[64:ShiftA];
    r_dd_q  <= (p_nod_q || !rdv_q) ? '0 : rd_q;
    // Sum stage
    s_y_q   <= r_y_q;
    s_wa_q  <= r_wa_q;
    s_ma_q  <= ma_full;
    s_s1_q  <= sat64(65'(r_mb_q) + 65'(r_dd_q));
    // Filter output of the current filter
    if (s_vld_q && s_y_q) begin
      y_q <= t_val;
    end
    // Capture the scaled outputs once each filter output settles
    if (state_q == StRun && cnt_q == CW'(LpKStart)) begin
      lp_q <= y_out;
    end
    if (state_q == StRun && cnt_q == CW'(HpKStart)) begin
      hp_q <= y_out;
    end
    // Output register
    if (load_out) begin
      out_lp_q <= lp_q;
      out_hp_q <= hp_q;
    end
  end

  // Checks
  `CIIR_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_xfer, (state_q == StRun) && (cnt_q == '0), "sample transfer did not start the schedule")
  `CIIR_ASSERT_SAME(a_drained_at_end, clk_i, rst_ni, (state_q == StRun) && (cnt_q == CW'(LastCnt)), !p_vld_q && !r_vld_q, "tap pipeline not drained at end of sample")
  `CIIR_ASSERT_SAME(a_no_rw_collide, clk_i, rst_ni, rd_en && wr_en, rd_addr != s_wa_q, "state read and write hit the same entry")
  `CIIR_ASSERT_SAME(a_idle_quiet, clk_i, rst_ni, state_q == StIdle, !iss_vld && !wr_en && !r_vld_q, "tap activity while idle")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the cascaded low-pass / high-pass IIR filter
// Streams signed samples into the block: a directed set of extremes, steps,
// impulses and full-scale alternation, then random samples under several
// idle and stall mixes and one long output hold-off. A bit-exact
// fixed-point predictor of both filter stages forms the expected outputs,
// and every output transfer is compared with them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int TapOrder   = 4;
localparam int StateW     = 48;
localparam int ResW       = 24;
localparam int InRound    = 5;
localparam int FbRound    = 27;
localparam int ResShift   = 22;
localparam int TapPeriod  = 2 * TapOrder + 12;

// Q5.27 coefficients, low-pass row then high-pass row
localparam longint FeedFwd [2][TapOrder+1] = '{
  '{433123, 1732494, 2598741, 1732494, 433123},
  '{130355587, -521422350, 782133524, -521422350, 130355587}};
localparam longint FeedBack [2][TapOrder+1] = '{
  '{134217728, -341999886, 350298370, -166047058, 30460821},
  '{134217728, -529033588, 782022407, -513811095, 126604581}};

typedef struct packed {
  logic signed [ResW-1:0] highpass;
  logic signed [ResW-1:0] lowpass;
} filter_out_t;

class filter_scoreboard;
  longint      delay_line [2][TapOrder];
  filter_out_t expected_outputs [$];
  int unsigned fails;

  function new();
    for (int f = 0; f < 2; f++) begin
      for (int k = 0; k < TapOrder; k++) begin
        delay_line[f][k] = 0;
      end
    end
    fails = 0;
  endfunction

  // Add with saturation at 64 signed bits
  function longint sat_add(longint p, longint q);
    logic signed [64:0] sum;
    sum = p;
    sum = sum + q;
    if (sum[64] != sum[63]) begin
      return sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return sum[63:0];
  endfunction

  function longint clamp_width(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // c * v / 2^s rounded half up, high partial product clamped first
  function longint round_product(longint c, longint v, int s);
    longint vh;
    longint vl;
    longint hi;
    longint lo;
    longint bound;
    vh = v >>> 32;
    vl = v & 64'h0000_0000_FFFF_FFFF;
    hi = c * vh;
    lo = c * vl + (longint'(1) <<< (s - 1));
    bound = longint'(1) <<< (30 + s);
    if (hi > bound) hi = bound;
    if (hi < -bound) hi = -bound;
    return hi * (longint'(1) <<< (32 - s)) + (lo >>> s);
  endfunction

  // One transposed direct form II step; u has 8 fraction bits, y has 30
  function longint filter_step(logic filt, longint u);
    longint y;
    longint t;
    y = clamp_width(sat_add(round_product(FeedFwd[filt][0], u, InRound),
                            delay_line[filt][0]), StateW);
    for (int k = 1; k < TapOrder; k++) begin
      t = sat_add(round_product(FeedFwd[filt][k], u, InRound), delay_line[filt][k]);
      t = sat_add(t, -round_product(FeedBack[filt][k], y, FbRound));
      delay_line[filt][k-1] = clamp_width(t, StateW);
    end
    delay_line[filt][TapOrder-1] = clamp_width(
      sat_add(round_product(FeedFwd[filt][TapOrder], u, InRound),
              -round_product(FeedBack[filt][TapOrder], y, FbRound)), StateW);
    return y;
  endfunction

  function longint to_output(longint y);
    return clamp_width(sat_add(y, longint'(1) <<< (ResShift - 1)) >>> ResShift, ResW);
  endfunction

  // Advance both filters by one accepted sample and queue the outputs
  function void note_sample(logic signed [ciir_pkg::SampleW-1:0] s);
    longint      lp;
    longint      hp;
    filter_out_t res;
    lp = to_output(filter_step(ciir_pkg::FiltLp, longint'(s) * 256));
    hp = to_output(filter_step(ciir_pkg::FiltHp, lp));
    res.lowpass  = lp[ResW-1:0];
    res.highpass = hp[ResW-1:0];
    expected_outputs.push_back(res);
  endfunction

  // Compare one output transfer with the oldest expected outputs
  function void check_output(logic [2*ciir_pkg::OutW-1:0] tdata);
    filter_out_t res;
    if (expected_outputs.size() == 0) begin
      $display("%0t: unexpected output transfer, tdata %h", $time, tdata);
      fails++;
      return;
    end
    res = expected_outputs.pop_front();
    if (tdata[ResW-1:0] !== res.lowpass) begin
      $display("%0t: lowpass_out mismatch: expected %0d, actual %0d",
               $time, res.lowpass, $signed(tdata[ResW-1:0]));
      fails++;
    end
    if (tdata[2*ResW-1:ResW] !== res.highpass) begin
      $display("%0t: highpass_out mismatch: expected %0d, actual %0d",
               $time, res.highpass, $signed(tdata[2*ResW-1:ResW]));
      fails++;
    end
  endfunction

  function int pending();
    return expected_outputs.size();
  endfunction
endclass

module tb_top;

  localparam int LongHold    = 400;
  localparam int PhaseItems  = 185;
  localparam int DrainCycles = 4 * TapPeriod;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic [ciir_pkg::SampleW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [2*ciir_pkg::OutW-1:0]   m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  filter_scoreboard board;

  cascaded_iir_lowpass_highpass i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both sides at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_output(m_axis_tdata);
    end
  end

  // Drive the output ready: random stalls, or a long hold when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_sample(input logic [ciir_pkg::SampleW-1:0] s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin
    logic [ciir_pkg::SampleW-1:0] directed [$];
    logic [ciir_pkg::SampleW-1:0] s;
    logic [ciir_pkg::SampleW-1:0] last_sample;
    int unsigned                  idle_mix [4];
    int unsigned                  stall_mix [4];

    board = new();
    idle_mix  = '{0, 53, 0, 17};
    stall_mix = '{0, 0, 53, 17};
    last_sample = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Impulse, full-scale steps both ways, full-scale alternation, bit patterns
    directed = '{16'h0000, 16'h7FFF, 16'h0000, 16'h0000,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000};
    foreach (directed[i]) send_sample(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_mix[ph];
      sink_stall_pct = stall_mix[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        // Hold the output off while samples keep coming, to back up the input
        if (ph == 0 && n == 60) hold_reqs++;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: s = 16'($urandom);
          4, 5:       s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          6, 7:       s = last_sample + 16'($urandom_range(0, 511)) - 16'd256;
          default:    s = 16'($urandom_range(0, 63)) - 16'd32;
        endcase
        last_sample = s;
        send_sample(s);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding outputs, then watch for strays
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
